// ===== rtl/max_tracking_stack_unit_defines.svh =====
// Assertion macros used by the max tracking stack top level.
`ifndef MAX_TRACKING_STACK_UNIT_DEFINES_SVH
`define MAX_TRACKING_STACK_UNIT_DEFINES_SVH

// Condition must hold at every rising clock edge out of reset.
`define MTS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
// Types and constants of the max tracking stack.
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 9;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] max_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic [1:0]               status;
  } out_item_t;

  // Stack entry: value and the running maximum at that depth.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] max;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/max_tracking_stack_unit.sv =====
// Top level of the max tracking stack: stack control, entry RAM, result register.
// Push, query, refused op or pop that empties: result registered the cycle after transfer.
// Pop leaving one or more entries: RAM read of the new top entry, then the result register.
// One push or query per cycle unless output stalls; a pop leaving entries stalls input in S_POP.
// Reset empties the stack; RAM contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "max_tracking_stack_unit_defines.svh"
module max_tracking_stack_unit #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire mts_pkg::in_item_t in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      mts_pkg::out_item_t out_data
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = $bits(mts_pkg::entry_t);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic                             state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic signed [mts_pkg::DATA_W-1:0] top_r, top_nxt;
  logic signed [mts_pkg::DATA_W-1:0] max_r, max_nxt;

  logic                             accept;
  logic                             out_free;
  logic                             res_load;
  logic [1:0]                       res_status;
  logic [CNT_W-1:0]                 cnt_m2;
  logic signed [mts_pkg::DATA_W-1:0] push_max;
  logic [CNT_W+mts_pkg::COUNT_W-1:0] cnt_ext;
  mts_pkg::out_item_t               res;

  logic                             ram_we;
  mts_pkg::entry_t                  ram_wdata;
  logic [EW-1:0]                    ram_rdata;
  mts_pkg::entry_t                  rd_entry;

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign cnt_m2   = cnt_r - CNT_W'(2);
  assign rd_entry = mts_pkg::entry_t'(ram_rdata);
  assign push_max = ((cnt_r == '0) || (in_data.value > max_r)) ? in_data.value : max_r;

  assign ram_wdata.value = in_data.value;
  assign ram_wdata.max   = push_max;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    max_nxt    = max_r;
    ram_we     = 1'b0;
    res_load   = 1'b0;
    res_status = mts_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.op)
            mts_pkg::OP_PUSH: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_status = mts_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                top_nxt = in_data.value;
                max_nxt = push_max;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              res_load = 1'b1;
            end
            mts_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                res_status = mts_pkg::ST_EMPTY;
                res_load   = 1'b1;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
                if (cnt_r >= CNT_W'(2)) begin
                  state_nxt = S_POP;
                end else begin
                  res_load = 1'b1;
                end
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        top_nxt   = rd_entry.value;
        max_nxt   = rd_entry.max;
        res_load  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_ext          = (CNT_W + mts_pkg::COUNT_W)'(cnt_nxt);
    res.count        = cnt_ext[mts_pkg::COUNT_W-1:0];
    res.is_empty     = (cnt_nxt == '0);
    res.top_value    = (cnt_nxt == '0) ? '0 : top_nxt;
    res.max_value    = (cnt_nxt == '0) ? '0 : max_nxt;
    res.status       = res_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    max_r <= max_nxt;
  end

  mts_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(cnt_m2[AW-1:0]),
    .rdata(ram_rdata)
  );

  mts_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .load_data(res),
    .free     (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `MTS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "entry count above depth")
  `MTS_ASSERT_ALWAYS(a_pop_outfree, (state_r != S_POP) || !out_valid,
                     "pop read pending while a result is held")
  `MTS_ASSERT_NEXT(a_push_inc,
                   accept && (in_data.op == mts_pkg::OP_PUSH) && (cnt_r != CNT_W'(DEPTH)),
                   cnt_r == $past(cnt_r) + CNT_W'(1), "push did not grow the stack")
  `MTS_ASSERT_NEXT(a_pop_result, state_r == S_POP,
                   out_valid && (state_r == S_IDLE), "pop result not delivered")

endmodule
`default_nettype wire

// ===== rtl/mts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/mts_out_reg.sv =====
// Result holding register for the output transfer.
`timescale 1ns / 1ps
`default_nettype none
module mts_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire mts_pkg::out_item_t load_data,
  output      logic               free,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      mts_pkg::out_item_t out_data
);

  logic               valid_r;
  logic               valid_nxt;
  mts_pkg::out_item_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_max_tracking_stack_unit.sv =====
// Self-checking testbench of the max tracking stack: random and directed stack traffic.
`timescale 1ns / 1ps
module tb_max_tracking_stack_unit;
  import mts_pkg::*;

  localparam int          STACK_DEPTH   = DEPTH_DEF;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int          RANDOM_ITEMS  = 1300;
  localparam int          LONG_HOLD     = 400;
  localparam int          QUIET_LIMIT   = 5000;
  localparam int          REPORT_LIMIT  = 10;

  class max_stack_scoreboard;
    logic signed [DATA_W-1:0] pushed_values[STACK_DEPTH];
    logic signed [DATA_W-1:0] running_max[STACK_DEPTH];
    int unsigned              level;
    out_item_t                expected_results[$];
    int                       failures;

    function new();
      level    = 0;
      failures = 0;
    endfunction

    // Apply one accepted operation to the shadow stack and queue its result.
    function void note_input(in_item_t item);
      out_item_t                exp;
      logic signed [DATA_W-1:0] m;
      exp        = '0;
      exp.status = ST_OK;
      if (item.op == OP_PUSH) begin
        if (level >= STACK_DEPTH) begin
          exp.status = ST_FULL;
        end else begin
          m = item.value;
          if (level > 0 && running_max[level-1] > m) m = running_max[level-1];
          pushed_values[level] = item.value;
          running_max[level]   = m;
          level++;
        end
      end else if (item.op == OP_POP) begin
        if (level == 0) exp.status = ST_EMPTY;
        else level--;
      end
      if (level > 0) begin
        exp.top_value = pushed_values[level-1];
        exp.max_value = running_max[level-1];
      end
      exp.count    = level[COUNT_W-1:0];
      exp.is_empty = (level == 0);
      expected_results.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: result with nothing expected: top=%0d max=%0d count=%0d",
                   got.top_value, got.max_value, got.count);
        return;
      end
      exp = expected_results.pop_front();
      if (got.top_value !== exp.top_value || got.max_value !== exp.max_value ||
          got.count !== exp.count || got.is_empty !== exp.is_empty ||
          got.status !== exp.status) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("ERROR: exp top=%0d max=%0d count=%0d empty=%0b status=%0d",
                   exp.top_value, exp.max_value, exp.count, exp.is_empty, exp.status);
          $display("       got top=%0d max=%0d count=%0d empty=%0b status=%0d",
                   got.top_value, got.max_value, got.count, got.is_empty, got.status);
        end
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  max_stack_scoreboard sb = new();

  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  bit hold_wanted   = 1'b0;
  bit hold_done     = 1'b0;
  bit draining      = 1'b0;
  int quiet_cycles  = 0;

  max_tracking_stack_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(item);
  endtask

  task automatic send_op(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
    in_item_t item;
    item.op    = op;
    item.value = v;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      4, 5: return $signed($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Biased walk: fill toward full, then drain toward empty, to hit both limits.
  task automatic send_random();
    in_item_t item;
    int       roll;
    if (!draining && sb.level >= STACK_DEPTH && $urandom_range(3) == 0) draining = 1'b1;
    else if (draining && sb.level == 0 && $urandom_range(3) == 0) draining = 1'b0;
    else if ($urandom_range(63) == 0) draining = !draining;
    roll = $urandom_range(99);
    if (roll < 75) item.op = draining ? OP_POP : OP_PUSH;
    else if (roll < 87) item.op = draining ? OP_PUSH : OP_POP;
    else if (roll < 97) item.op = OP_QUERY;
    else item.op = OP_UNUSED;
    item.value = pick_value();
    send_item(item);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 21;
    rcv_idle_pct  = 67;

    send_op(OP_QUERY,  32'sd0);
    send_op(OP_POP,    32'sd0);
    send_op(OP_UNUSED, 32'h5A5A_A5A5);
    send_op(OP_PUSH,   32'h8000_0000);
    send_op(OP_PUSH,   32'h7FFF_FFFF);
    send_op(OP_PUSH,   32'sd0);
    send_op(OP_PUSH,   -32'sd1);
    send_op(OP_QUERY,  32'hFFFF_FFFF);
    send_op(OP_UNUSED, 32'h7FFF_FFFF);
    send_op(OP_POP,    32'h1234_5678);
    send_op(OP_POP,    32'sd0);
    send_op(OP_POP,    32'sd0);
    send_op(OP_POP,    32'sd0);
    send_op(OP_POP,    32'h8000_0000);
    send_op(OP_PUSH,   32'sd5);
    send_op(OP_PUSH,   32'sd5);
    send_op(OP_PUSH,   32'sd3);
    send_op(OP_PUSH,   32'sd7);
    send_op(OP_POP,    32'sd0);
    send_op(OP_POP,    32'sd0);
    send_op(OP_POP,    32'sd0);
    send_op(OP_POP,    32'sd0);
    send_op(OP_QUERY,  32'sd0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 67 : 0;
      rcv_idle_pct  = (phase == 0) ? 67 : (phase == 1) ? 21 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        if (phase == 2 && n == 100) hold_wanted = 1'b1;
        send_random();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
